// File: rtl/rbbe_pkg.sv
package rbbe_pkg;

	// Default depth of the range bound tables.
	localparam int MAX_RANGES_DEF = 16;

	// Bitmap word width, fixed by the width of the result word.
	localparam int WORD_BITS = 32;
	localparam int BIT_W     = $clog2(WORD_BITS);

	// Field widths of the channels and of the configuration port.
	localparam int NUM_RANGES_W = 5;
	localparam int ENTRY_W      = 4;
	localparam int VALUE_W      = 32;
	localparam int BIN_INDEX_W  = 5;
	localparam int WORD_INDEX_W = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 5;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_NUM_RANGES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BELOW_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ABOVE_EN   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIGNED     = 2'd3;

	// Input item operation codes.
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_VALUE = 1'b1;

	// Result of the shared key comparator: key below bound, key equal to bound.
	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

	// Control of the bitmap accumulators.
	typedef struct packed {
		logic             set_en;
		logic             clear;
		logic [BIT_W-1:0] set_bit;
	} acc_ctl_t;

endpackage

// File: rtl/rbbe_in_if.sv
interface rbbe_in_if import rbbe_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               op;
	logic [ENTRY_W-1:0] entry_index;
	logic [VALUE_W-1:0] range_low;
	logic [VALUE_W-1:0] range_high;
	logic [VALUE_W-1:0] sample_value;
	logic               last_value;

	modport source (
		output valid, op, entry_index, range_low, range_high, sample_value, last_value,
		input  ready
	);

	modport sink (
		input  valid, op, entry_index, range_low, range_high, sample_value, last_value,
		output ready
	);
endinterface

// File: rtl/rbbe_out_if.sv
interface rbbe_out_if import rbbe_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [BIN_INDEX_W-1:0]  bin_index;
	logic [WORD_INDEX_W-1:0] word_index;
	logic [WORD_BITS-1:0]    bitmap_word;
	logic                    last_word;

	modport source (
		output valid, bin_index, word_index, bitmap_word, last_word,
		input  ready
	);

	modport sink (
		input  valid, bin_index, word_index, bitmap_word, last_word,
		output ready
	);
endinterface

// File: rtl/rbbe_bound_ram.sv
module rbbe_bound_ram import rbbe_pkg::*; #(
	parameter int DEPTH = MAX_RANGES_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [VALUE_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output logic [VALUE_W-1:0] rdata
);

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	// One write port and one registered read port; read data holds until the next read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/rbbe_key_cmp.sv
module rbbe_key_cmp import rbbe_pkg::*; (
	input  logic [VALUE_W-1:0] key,
	input  logic [VALUE_W-1:0] bound,
	input  logic               signed_cmp,
	output cmp_res_t           res
);

	logic [VALUE_W-1:0] bound_key;

	// Flipping the sign bit maps two's complement order onto unsigned order.
	assign bound_key = bound ^ {signed_cmp, {(VALUE_W-1){1'b0}}};
	assign res.lt    = key < bound_key;
	assign res.eq    = key == bound_key;

endmodule

// File: rtl/rbbe_bitmap_acc.sv
module rbbe_bitmap_acc import rbbe_pkg::*; #(
	parameter int BIN_SLOTS = MAX_RANGES_DEF + 2,
	localparam int BW       = $clog2(BIN_SLOTS)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  acc_ctl_t             ctl,
	input  logic [BW-1:0]        set_bin,
	input  logic [BW-1:0]        rd_bin,
	output logic [WORD_BITS-1:0] rd_word
);

	logic [WORD_BITS-1:0] acc_q [BIN_SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < BIN_SLOTS; b++) begin
				acc_q[b] <= '0;
			end
		end else if (ctl.clear) begin
			for (int b = 0; b < BIN_SLOTS; b++) begin
				acc_q[b] <= '0;
			end
		end else if (ctl.set_en) begin
			acc_q[set_bin][ctl.set_bit] <= 1'b1;
		end
	end

	assign rd_word = acc_q[rd_bin];

endmodule

// File: rtl/range_binned_bitmap_encoder_top.sv
// Channel   Direction  Handshake      Payload
// cfg       in         cfg_we         cfg_index, cfg_wdata (register write, no back-pressure)
// in_ch     in         valid / ready  op, entry_index, range_low, range_high, sample_value,
//                                     last_value
// out_ch    out        valid / ready  bin_index, word_index, bitmap_word, last_word
//
// A load item is written straight into both bound tables.
// For a value item, where n is the number of ranges in use, one shared key comparator
// walks the low bound table one entry a cycle through its registered read port to count
// the bounds below the value, then checks the two candidate bounds.
// A flush emits one word per bin in use, n plus the enabled below and above bins, from
// the accumulators through the output register; a stalled output holds the flush.
// Reset clears the control state, the configuration and all bitmap accumulators at
// once; the bound tables hold no reset value and must be loaded before use.
// The input is not ready while an item is being worked on or a flush is in progress.
module range_binned_bitmap_encoder_top import rbbe_pkg::*; #(
	parameter int MAX_RANGES = MAX_RANGES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	rbbe_in_if.sink               in_ch,
	rbbe_out_if.source            out_ch
);

	localparam int ADDR_W    = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W     = $clog2(MAX_RANGES + 1);
	localparam int BIN_SLOTS = MAX_RANGES + 2;
	localparam int BIN_W     = $clog2(BIN_SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FETCH,
		ST_CMP_LOW,
		ST_CMP_HIGH,
		ST_FLUSH
	} state_t;

	// Configuration registers.
	logic [NUM_RANGES_W-1:0] num_ranges_q;
	logic                    below_en_q;
	logic                    above_en_q;
	logic                    signed_cmp_q;

	// Sequencer state.
	state_t                  state_q;
	logic [VALUE_W-1:0]      key_q;
	logic                    last_q;
	logic [CNT_W-1:0]        scan_idx_q;
	logic                    rd_vld_q;
	logic [CNT_W-1:0]        pos_q;
	logic                    low_eq_q;
	logic [BIT_W-1:0]        bit_pos_q;
	logic [WORD_INDEX_W-1:0] word_cnt_q;
	logic [BIN_W-1:0]        flush_bin_q;

	// Output register.
	logic                    out_valid_q;
	logic [BIN_INDEX_W-1:0]  out_bin_q;
	logic [WORD_INDEX_W-1:0] out_word_idx_q;
	logic [WORD_BITS-1:0]    out_word_q;
	logic                    out_last_q;

	logic [CNT_W-1:0]        n_rng;
	logic [BIN_W-1:0]        bins_used;
	logic                    in_accept;
	logic                    load_we;
	logic                    scan_issue;
	logic                    low_re;
	logic                    high_re;
	logic [ADDR_W-1:0]       low_raddr;
	logic [ADDR_W-1:0]       high_raddr;
	logic [VALUE_W-1:0]      low_rdata;
	logic [VALUE_W-1:0]      high_rdata;
	logic [VALUE_W-1:0]      cmp_bound;
	cmp_res_t                cmp;
	logic                    bound_below;
	logic                    hit;
	logic [BIN_W-1:0]        hit_bin;
	logic [BIN_W-1:0]        below_ofs;
	acc_ctl_t                acc_ctl;
	logic [WORD_BITS-1:0]    acc_rd_word;
	logic                    word_done;
	logic                    out_free;
	logic                    flush_load;
	logic                    flush_last;
	logic                    flush_done;

	// Configuration writes; the user writes the port only while idle; not enforced.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_ranges_q <= NUM_RANGES_W'(1);
			below_en_q   <= 1'b0;
			above_en_q   <= 1'b0;
			signed_cmp_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUM_RANGES: num_ranges_q <= cfg_wdata[NUM_RANGES_W-1:0];
				REG_BELOW_EN:   below_en_q   <= cfg_wdata[0];
				REG_ABOVE_EN:   above_en_q   <= cfg_wdata[0];
				REG_SIGNED:     signed_cmp_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// A range count of zero acts as one, and a count past the table depth is clamped.
	always_comb begin
		if (num_ranges_q == '0) begin
			n_rng = CNT_W'(1);
		end else if (int'(num_ranges_q) > MAX_RANGES) begin
			n_rng = CNT_W'(MAX_RANGES);
		end else begin
			n_rng = CNT_W'(num_ranges_q);
		end
	end

	assign below_ofs = BIN_W'(below_en_q);
	assign bins_used = BIN_W'(n_rng) + below_ofs + BIN_W'(above_en_q);

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_accept   = in_ch.valid && in_ch.ready;

	// Load items with an index beyond the table are dropped.
	assign load_we = in_accept && (in_ch.op == OP_LOAD) &&
		(int'(in_ch.entry_index) < MAX_RANGES);

	// The scan issues one low bound read a cycle; the fetch step reads the low bound at
	// the counted position and the high bound just before it.
	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q != n_rng);
	assign low_re     = scan_issue || (state_q == ST_FETCH);
	assign high_re    = (state_q == ST_FETCH);

	always_comb begin
		if (state_q == ST_FETCH) begin
			low_raddr = (pos_q != n_rng) ? ADDR_W'(pos_q) : '0;
		end else begin
			low_raddr = ADDR_W'(scan_idx_q);
		end
		high_raddr = (pos_q != '0) ? ADDR_W'(pos_q - CNT_W'(1)) : '0;
	end

	rbbe_bound_ram #(
		.DEPTH (MAX_RANGES)
	) u_low_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (ADDR_W'(in_ch.entry_index)),
		.wdata (in_ch.range_low),
		.re    (low_re),
		.raddr (low_raddr),
		.rdata (low_rdata)
	);

	rbbe_bound_ram #(
		.DEPTH (MAX_RANGES)
	) u_high_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (ADDR_W'(in_ch.entry_index)),
		.wdata (in_ch.range_high),
		.re    (high_re),
		.raddr (high_raddr),
		.rdata (high_rdata)
	);

	// The single comparator serves the scan, the low bound check and the high bound check.
	assign cmp_bound = (state_q == ST_CMP_HIGH) ? high_rdata : low_rdata;

	rbbe_key_cmp u_cmp (
		.key        (key_q),
		.bound      (cmp_bound),
		.signed_cmp (signed_cmp_q),
		.res        (cmp)
	);

	assign bound_below = !cmp.lt && !cmp.eq;

	// Bin decision, made in the high bound step. With no low bound below the value, the
	// value either matches the first low bound or lies below the whole table. With every
	// low bound below it, it is either inside the last range or above it.
	always_comb begin
		hit     = 1'b0;
		hit_bin = '0;
		if (pos_q == '0) begin
			if (low_eq_q) begin
				hit     = 1'b1;
				hit_bin = below_ofs;
			end else begin
				hit     = below_en_q;
				hit_bin = '0;
			end
		end else if (pos_q == n_rng) begin
			if (cmp.lt) begin
				hit     = 1'b1;
				hit_bin = BIN_W'(pos_q) - BIN_W'(1) + below_ofs;
			end else begin
				hit     = above_en_q;
				hit_bin = BIN_W'(n_rng) + below_ofs;
			end
		end else begin
			if (low_eq_q) begin
				hit     = 1'b1;
				hit_bin = BIN_W'(pos_q) + below_ofs;
			end else if (cmp.lt) begin
				hit     = 1'b1;
				hit_bin = BIN_W'(pos_q) - BIN_W'(1) + below_ofs;
			end
		end
	end

	assign word_done  = (bit_pos_q == BIT_W'(WORD_BITS - 1)) || last_q;
	assign out_free   = !out_valid_q || out_ch.ready;
	assign flush_load = (state_q == ST_FLUSH) && out_free;
	assign flush_last = (flush_bin_q == bins_used - BIN_W'(1));
	assign flush_done = flush_load && flush_last;

	// The earliest value of a word lands in the top bit.
	assign acc_ctl.set_en  = (state_q == ST_CMP_HIGH) && hit;
	assign acc_ctl.clear   = flush_done;
	assign acc_ctl.set_bit = BIT_W'(WORD_BITS - 1) - bit_pos_q;

	rbbe_bitmap_acc #(
		.BIN_SLOTS (BIN_SLOTS)
	) u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (acc_ctl),
		.set_bin (hit_bin),
		.rd_bin  (flush_bin_q),
		.rd_word (acc_rd_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '0;
			last_q         <= 1'b0;
			scan_idx_q     <= '0;
			rd_vld_q       <= 1'b0;
			pos_q          <= '0;
			low_eq_q       <= 1'b0;
			bit_pos_q      <= '0;
			word_cnt_q     <= '0;
			flush_bin_q    <= '0;
			out_valid_q    <= 1'b0;
			out_bin_q      <= '0;
			out_word_idx_q <= '0;
			out_word_q     <= '0;
			out_last_q     <= 1'b0;
		end else begin
			if (flush_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_ch.op == OP_VALUE)) begin
						key_q      <= in_ch.sample_value ^
							{signed_cmp_q, {(VALUE_W-1){1'b0}}};
						last_q     <= in_ch.last_value;
						scan_idx_q <= '0;
						pos_q      <= '0;
						rd_vld_q   <= 1'b0;
						state_q    <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					rd_vld_q <= scan_issue;
					if (rd_vld_q && bound_below) begin
						pos_q <= pos_q + CNT_W'(1);
					end
					if (rd_vld_q && !scan_issue) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					state_q <= ST_CMP_LOW;
				end
				ST_CMP_LOW: begin
					low_eq_q <= cmp.eq;
					state_q  <= ST_CMP_HIGH;
				end
				ST_CMP_HIGH: begin
					bit_pos_q <= bit_pos_q + BIT_W'(1);
					if (word_done) begin
						flush_bin_q <= '0;
						state_q     <= ST_FLUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						out_bin_q      <= BIN_INDEX_W'(flush_bin_q);
						out_word_idx_q <= word_cnt_q;
						out_word_q     <= acc_rd_word;
						out_last_q     <= flush_last;
						if (flush_last) begin
							bit_pos_q  <= '0;
							word_cnt_q <= word_cnt_q + WORD_INDEX_W'(1);
							state_q    <= ST_IDLE;
						end else begin
							flush_bin_q <= flush_bin_q + BIN_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.bin_index   = out_bin_q;
	assign out_ch.word_index  = out_word_idx_q;
	assign out_ch.bitmap_word = out_word_q;
	assign out_ch.last_word   = out_last_q;

	// The position count never passes the number of ranges in use.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (pos_q <= n_rng) && (scan_idx_q <= n_rng))
		else $error("range position count out of bounds");

	// A bit is only ever set in a bin that a flush will emit.
	a_set_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_ctl.set_en |-> (hit_bin < bins_used))
		else $error("bitmap bit set in a bin that is not in use");

	// A full word always leads into a flush.
	a_full_word: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_CMP_HIGH) && (bit_pos_q == BIT_W'(WORD_BITS - 1))) |=>
		(state_q == ST_FLUSH))
		else $error("full bitmap word not flushed");

	// The end of a flush restarts the bit position and advances the word counter.
	a_flush_end: assert property (@(posedge clk) disable iff (!arst_n)
		flush_done |=> (bit_pos_q == '0) &&
		(word_cnt_q == WORD_INDEX_W'($past(word_cnt_q) + WORD_INDEX_W'(1))))
		else $error("flush did not restart the word");

endmodule
